[rtl/tat_pkg.sv]
// Package for the tick alarm table: shared constants, codes and beat structures.
// Used by every module of the block but tat_ram, and by its checker; depends on nothing.
`default_nettype none

package tat_pkg;

  // Defaults for the module parameters.
  localparam int unsigned AlarmSlotsDef = 16;
  localparam int unsigned TagBitsDef    = 8;

  // Fixed field widths of the ports.
  localparam int unsigned TickW = 32;
  localparam int unsigned TagW  = 8;

  // Depth of the small queues on either side of the slot engine.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ADD  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_FIRED  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_PAST = 2'd1,
    CAUSE_FULL = 2'd2
  } cause_e;

  // One decoded command handed from the front end to the slot engine.
  typedef struct packed {
    op_e              op;
    logic [TickW-1:0] expiry;
    logic [TagW-1:0]  tag;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    kind_e            kind;
    logic [TagW-1:0]  tag;
    cause_e           cause;
    logic [TickW-1:0] tick;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

[rtl/tat_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the expiry and tag of every alarm slot.
`default_nettype none

module tat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port; contents are not reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/tat_front.sv]
// Front end of the tick alarm table: accepts input beats into a short queue
// and decodes them into commands for the slot engine. Depends on tat_pkg.
`default_nettype none

module tat_front
  import tat_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            op_i,
  input  wire logic [TickW-1:0] expiry_time_i,
  input  wire logic [TagW-1:0] alarm_tag_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  wire logic            cmd_ready_i
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_q [QueueDepth];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;
  cmd_t            cmd_in;

  // Decode the incoming beat.
  always_comb begin
    cmd_in.op     = op_i ? OP_ADD : OP_TICK;
    cmd_in.expiry = expiry_time_i;
    cmd_in.tag    = alarm_tag_i;
  end

  assign full        = (cnt_q == CntW'(QueueDepth));
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign do_pop      = cmd_ready_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[rtl/tat_back.sv]
// Slot engine of the tick alarm table: holds the tick counter and slot valid
// bits, places new alarms and scans the slot RAM on each tick. Uses tat_pkg, tat_ram.
`default_nettype none

module tat_back
  import tat_pkg::*;
#(
  parameter int unsigned AlarmSlots = AlarmSlotsDef,
  parameter int unsigned TagBits    = TagBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_ready_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  localparam int unsigned SlotW = (AlarmSlots > 1) ? $clog2(AlarmSlots) : 1;
  localparam int unsigned EntW  = TickW + TagBits;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(AlarmSlots - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [SlotW-1:0]        idx_q, idx_d;
  logic [TickW-1:0]        tick_q, tick_d;
  logic [AlarmSlots-1:0]   valid_q, valid_d;

  logic                    free_found;
  logic [SlotW-1:0]        free_idx;
  logic                    ram_we, ram_re;
  logic [SlotW-1:0]        ram_raddr;
  logic [EntW-1:0]         ram_wdata, ram_rdata;
  logic [TickW-1:0]        rd_expiry, diff;
  logic [TagBits-1:0]      rd_tag;
  logic                    fire;

  tat_ram #(
    .Width(EntW),
    .Depth(AlarmSlots)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = AlarmSlots - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  // Expiry check on the slot held at the registered RAM read port: wrap-safe signed difference.
  assign rd_expiry = ram_rdata[TagBits +: TickW];
  assign rd_tag    = ram_rdata[TagBits-1:0];
  assign diff      = rd_expiry - tick_q;
  assign fire      = valid_q[idx_q] && diff[TickW-1];
  assign ram_wdata = {cmd_i.expiry, TagBits'(cmd_i.tag)};

  // Next-state logic of the engine.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    tick_d      = tick_q;
    valid_d     = valid_q;
    cmd_ready_o = 1'b0;
    res_push_o  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx_q + SlotW'(1);
    res_o.kind  = KIND_TICK;
    res_o.tag   = '0;
    res_o.cause = CAUSE_NONE;
    res_o.tick  = tick_q;
    res_o.last  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = !res_full_i;
        if (cmd_valid_i && !res_full_i) begin
          if (cmd_i.op == OP_TICK) begin
            // Count the tick and start the scan at slot zero.
            tick_d    = tick_q + TickW'(1);
            idx_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = ST_SCAN;
          end else begin
            res_push_o = 1'b1;
            if (cmd_i.expiry < tick_q) begin
              res_o.kind  = KIND_REJECT;
              res_o.cause = CAUSE_PAST;
            end else if (free_found) begin
              res_o.kind        = KIND_ACCEPT;
              ram_we            = 1'b1;
              valid_d[free_idx] = 1'b1;
            end else begin
              res_o.kind  = KIND_REJECT;
              res_o.cause = CAUSE_FULL;
            end
          end
        end
      end
      ST_SCAN: begin
        if (fire) begin
          res_o.kind = KIND_FIRED;
          res_o.tag  = TagW'(rd_tag);
          res_o.last = 1'b0;
        end
        // Move on once any firing beat has been queued.
        if (!fire || !res_full_i) begin
          if (fire) begin
            res_push_o     = 1'b1;
            valid_d[idx_q] = 1'b0;
          end
          if (idx_q == LastSlot) begin
            state_d = ST_DONE;
          end else begin
            idx_d  = idx_q + SlotW'(1);
            ram_re = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      tick_q  <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      tick_q  <= tick_d;
      valid_q <= valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tat_resq.sv]
// Result queue of the tick alarm table: holds result beats until popped.
// Depends on tat_pkg.
`default_nettype none

module tat_resq
  import tat_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_push_i,
  input  wire res_t res_i,
  output logic      res_full_o,
  output logic      empty,
  input  wire logic pop,
  output res_t      res_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  res_t            entry_q [QueueDepth];
  logic            wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign res_full_o = (cnt_q == CntW'(QueueDepth));
  assign empty      = (cnt_q == '0);
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;
  assign res_o      = entry_q[rd_ptr_q];

  // Fill count follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

[rtl/tick_alarm_table.sv]
// Tick alarm table: an add passes through the input queue and the slot engine into the
// result queue; adds are taken one per cycle while the engine is idle and the result
// queue is not full. On a tick the engine reads slot zero, then checks one slot of the
// slot RAM per cycle unless a firing beat meets a full result queue, then queues the
// tick's done beat, and takes no new command until then. Asynchronous active-low reset
// clears the counter, the valid bits and both queues; slot RAM needs no clearing pass.
`default_nettype none

module tick_alarm_table
  import tat_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = AlarmSlotsDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             op_i,
  input  wire logic [TickW-1:0] expiry_time_i,
  input  wire logic [TagW-1:0]  alarm_tag_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic [1:0]            kind_o,
  output logic [TagW-1:0]       fired_tag_o,
  output logic [1:0]            reject_cause_o,
  output logic [TickW-1:0]      tick_value_o,
  output logic                  last_o
);

  logic cmd_valid, cmd_ready, res_full, res_push;
  cmd_t cmd;
  res_t res_in, res_out;

  tat_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .expiry_time_i(expiry_time_i),
    .alarm_tag_i  (alarm_tag_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  tat_back #(
    .AlarmSlots(ALARM_SLOTS),
    .TagBits   (TAG_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  tat_resq u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_push_i(res_push),
    .res_i     (res_in),
    .res_full_o(res_full),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_out)
  );

  // Result beat onto the ports.
  assign kind_o         = res_out.kind;
  assign fired_tag_o    = res_out.tag;
  assign reject_cause_o = res_out.cause;
  assign tick_value_o   = res_out.tick;
  assign last_o         = res_out.last;

endmodule

`default_nettype wire

[rtl/tat_checker.sv]
// Port-level checker for the tick alarm table, bound to the top level.
// Depends on tat_pkg and tick_alarm_table.
`default_nettype none

module tat_checker
  import tat_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             empty,
  input wire logic             pop,
  input wire logic [1:0]       kind_o,
  input wire logic [TagW-1:0]  fired_tag_o,
  input wire logic [1:0]       reject_cause_o,
  input wire logic [TickW-1:0] tick_value_o,
  input wire logic             last_o
);

  // A waiting result beat holds until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable({kind_o, fired_tag_o, reject_cause_o, tick_value_o, last_o}))
    else $error("result beat changed while stalled");

  // Only the final beat of an item is marked last, and fired beats never are.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (kind_o != KIND_FIRED)))
    else $error("last flag does not match result kind");

  // A rejection always carries a cause.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_REJECT) |->
      (reject_cause_o == CAUSE_PAST || reject_cause_o == CAUSE_FULL))
    else $error("rejection without a cause");

  // Every other beat carries no cause.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_REJECT) |-> (reject_cause_o == CAUSE_NONE))
    else $error("cause on a beat that is not a rejection");

  // Only fired beats carry a tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_FIRED) |-> (fired_tag_o == '0))
    else $error("tag on a beat that is not a firing");

endmodule

bind tick_alarm_table tat_checker u_tat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .kind_o        (kind_o),
  .fired_tag_o   (fired_tag_o),
  .reject_cause_o(reject_cause_o),
  .tick_value_o  (tick_value_o),
  .last_o        (last_o)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the tick alarm table: a directed sequence, then random ticks
// and adds under several idle and stall mixes, all checked against a behavioural predictor.
// Depends on tat_pkg and the tick_alarm_table top level.
`timescale 1ns / 1ps

module testbench;
  import tat_pkg::*;

  localparam int unsigned ALARM_SLOTS    = AlarmSlotsDef;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 2 * ALARM_SLOTS + 8;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             push      = 1'b0;
  logic             full;
  op_e              op_q      = OP_TICK;
  logic [TickW-1:0] expiry_q  = '0;
  logic [TagW-1:0]  tag_q     = '0;
  logic             empty;
  logic             pop       = 1'b0;
  logic [1:0]       kind_o;
  logic [TagW-1:0]  fired_tag_o;
  logic [1:0]       reject_cause_o;
  logic [TickW-1:0] tick_value_o;
  logic             last_o;

  // Predicted state of the alarm table.
  logic [TickW-1:0] tick_model;
  bit               slot_busy  [ALARM_SLOTS];
  logic [TickW-1:0] slot_expiry_m [ALARM_SLOTS];
  logic [TagW-1:0]  slot_tag_m [ALARM_SLOTS];

  // Results still owed by the block, oldest first.
  res_t alarm_results_q[$];

  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_ticket    = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  tick_alarm_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_q),
    .expiry_time_i (expiry_q),
    .alarm_tag_i   (tag_q),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .fired_tag_o   (fired_tag_o),
    .reject_cause_o(reject_cause_o),
    .tick_value_o  (tick_value_o),
    .last_o        (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Update the predicted table for one accepted item and queue the results it owes.
  task automatic predict_alarm_item(input op_e op, input logic [TickW-1:0] expiry,
                                    input logic [TagW-1:0] tag);
    res_t             r;
    logic [TickW-1:0] gap;
    bit               placed;
    placed = 1'b0;
    if (op == OP_TICK) begin
      tick_model = tick_model + 1;
      for (int s = 0; s < ALARM_SLOTS; s++) begin
        gap = slot_expiry_m[s] - tick_model;
        if (slot_busy[s] && gap[TickW-1]) begin
          slot_busy[s] = 1'b0;
          r = '{kind: KIND_FIRED, tag: slot_tag_m[s], cause: CAUSE_NONE,
                tick: tick_model, last: 1'b0};
          alarm_results_q.push_back(r);
        end
      end
      r = '{kind: KIND_TICK, tag: '0, cause: CAUSE_NONE, tick: tick_model, last: 1'b1};
      alarm_results_q.push_back(r);
    end else if (expiry < tick_model) begin
      r = '{kind: KIND_REJECT, tag: '0, cause: CAUSE_PAST, tick: tick_model, last: 1'b1};
      alarm_results_q.push_back(r);
    end else begin
      for (int s = 0; s < ALARM_SLOTS; s++) begin
        if (!placed && !slot_busy[s]) begin
          slot_busy[s]     = 1'b1;
          slot_expiry_m[s] = expiry;
          slot_tag_m[s]    = tag;
          placed           = 1'b1;
        end
      end
      if (placed) begin
        r = '{kind: KIND_ACCEPT, tag: '0, cause: CAUSE_NONE, tick: tick_model, last: 1'b1};
      end else begin
        r = '{kind: KIND_REJECT, tag: '0, cause: CAUSE_FULL, tick: tick_model, last: 1'b1};
      end
      alarm_results_q.push_back(r);
    end
  endtask

  // Offer one beat, after a random idle gap, and return at the edge that accepts it.
  // Always entered just after a rising edge; push stays high on return.
  task automatic send_beat(input op_e op, input logic [TickW-1:0] expiry,
                           input logic [TagW-1:0] tag);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    push     <= 1'b1;
    op_q     <= op;
    expiry_q <= expiry;
    tag_q    <= tag;
    do @(posedge clk_i); while (full);
    predict_alarm_item(op, expiry, tag);
  endtask

  // Stop offering beats and wait until every owed result has arrived, plus a settling pause.
  task automatic wait_drained();
    push <= 1'b0;
    while (alarm_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random add or tick, with expiries mostly close to the counter so that alarms fire.
  task automatic send_random_beat();
    logic [TickW-1:0] expiry;
    int unsigned      sel;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 55) begin
      expiry = $urandom;
      send_beat(OP_TICK, expiry, TagW'($urandom_range(0, 255)));
    end else begin
      if (sel < 60) begin
        expiry = tick_model + $urandom_range(0, 12);
      end else if (sel < 74) begin
        expiry = tick_model - $urandom_range(1, 4);
      end else if (sel < 94) begin
        // Half the counter range away: the wrap-safe compare sees it as already due.
        expiry = tick_model + 32'h8000_0000 + $urandom_range(1, 8);
      end else begin
        expiry = $urandom;
      end
      send_beat(OP_ADD, expiry, TagW'($urandom_range(0, 255)));
    end
  endtask

  // Edge cases of the compare, a full table and a tick that fires every slot.
  task automatic test_directed();
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_ADD, 32'h0000_0000, 8'hA5);
    send_beat(OP_ADD, tick_model, 8'h00);
    send_beat(OP_ADD, 32'hFFFF_FFFF, 8'hFF);
    send_beat(OP_ADD, tick_model + 32'h8000_0001, 8'h5A);
    send_beat(OP_TICK, 32'hFFFF_FFFF, 8'hFF);
    // Seventeen adds: sixteen fill the table, the last one is turned away as full.
    for (int i = 0; i <= ALARM_SLOTS; i++) begin
      send_beat(OP_ADD, tick_model, TagW'(8'hFF - 8'(i * 17)));
    end
    // Past expiry on a full table reports the past cause.
    send_beat(OP_ADD, 32'h0000_0000, 8'h3C);
    send_beat(OP_TICK, '0, '0);
    wait_drained();
  endtask

  // Random traffic under one mix of sender idling and receiver stalling.
  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) send_random_beat();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering beats.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ticket++;
    for (int i = 0; i < 24; i++) send_random_beat();
    wait_drained();
  endtask

  // Result checking, receiver stalls and the watchdog.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (alarm_results_q.size() == 0) begin
          $error("unexpected result beat: kind %0d, tick %0d", kind_o, tick_value_o);
          fail_count++;
        end else begin
          want = alarm_results_q.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            fail_count++;
          end
          if (fired_tag_o !== want.tag) begin
            $error("fired_tag: expected %0d, got %0d", want.tag, fired_tag_o);
            fail_count++;
          end
          if (reject_cause_o !== want.cause) begin
            $error("reject_cause: expected %0d, got %0d", want.cause, reject_cause_o);
            fail_count++;
          end
          if (tick_value_o !== want.tick) begin
            $error("tick_value: expected %0d, got %0d", want.tick, tick_value_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            fail_count++;
          end
        end
      end
      if ((pop && !empty) || (push && !full)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        if (hold_ticket != hold_served) begin
          hold_served = hold_ticket;
          hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          pop <= 1'b0;
        end else begin
          pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    tick_model = '0;
    for (int s = 0; s < ALARM_SLOTS; s++) begin
      slot_busy[s]     = 1'b0;
      slot_expiry_m[s] = '0;
      slot_tag_m[s]    = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 45);
    test_random_phase(81, 0, 45);
    test_backpressure();
    test_random_phase(0, 81, 45);
    test_random_phase(30, 30, 45);
    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tat_pkg.sv
rtl/tat_ram.sv
rtl/tat_front.sv
rtl/tat_back.sv
rtl/tat_resq.sv
rtl/tick_alarm_table.sv
rtl/tat_checker.sv
tb/testbench.sv
